>>> hdl/rsa_pkg.sv
// shared types and constants for the register slot allocator
package rsa_pkg;

	localparam int SLOT_W = 4;
	localparam int CAP_W = 5;
	localparam int CALC_W = 8;
	localparam int MAX_SLOTS_DEF = 16;

	localparam logic [CAP_W-1:0] SLOT_LIMIT = 5'd16;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_BULK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_NOTHING = 2'd2,
		ST_NO_INPUT = 2'd3
	} status_t;

	typedef struct packed {
		action_t action;
		logic is_store;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t status;
	} result_t;

endpackage

>>> hdl/register_slot_allocator.sv
// register slot allocator: free stack, input stack and output queue with a small sequencer
//
// Usage:
//   A command (cmd.action, cmd.is_store) is taken at a clock edge with start high and
//   busy low. Exactly one result per command appears on result for one cycle with done
//   high; the receiver cannot stall it, so it must take it in that cycle.
//   Path from the accepting edge to the done cycle:
//     error results (no free slot, nothing held, no input held): registered straight from S_IDLE
//     allocate, release from the input stack, query, single output release: via S_USE
//     release that moves an output queue entry: via S_USE, then S_MOVE
//     release of all inputs but the oldest: via S_USE, then S_BULK_RD and S_BULK_WR for each
//     input released. busy is low again in the done cycle, so the next command can go in
//   then; no new command is taken while one is in work. Each store has a single read
//   port, whose read data is registered before use.
//   capacity is written on the cfg channel (cfg_valid/cfg_ready) while idle; a
//   transfer refills the free stack and empties the input stack and output queue
//   at the transfer edge itself, no sweep is needed.
//   Reset (arst_n low) does the same refill with capacity 16.
module register_slot_allocator #(
	parameter int MAX_SLOTS = rsa_pkg::MAX_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  rsa_pkg::cmd_t             cmd,
	output logic                      done,
	output rsa_pkg::result_t          result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rsa_pkg::CAP_W-1:0] cfg_data
);
	import rsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int ADDR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_USE     = 5'b00010,
		S_MOVE    = 5'b00100,
		S_BULK_RD = 5'b01000,
		S_BULK_WR = 5'b10000
	} state_t;

	function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] v);
		logic [CAP_W-1:0] c;
		begin
			c = v;
			if (c == '0) c = CAP_W'(1);
			if (c > SLOT_LIMIT) c = SLOT_LIMIT;
			if (int'(c) > MAX_SLOTS) c = CAP_W'(MAX_SLOTS);
			return CNT_W'(c);
		end
	endfunction

	state_t state_q, state_d;
	logic [CNT_W-1:0] fc_q, fc_d, ic_q, ic_d, oc_q, oc_d, low_q, low_d, eff_q, eff_d;
	logic done_q, done_d;
	result_t result_q, res_d;
	cmd_t cmd_q, cmd_d;
	logic [SLOT_W-1:0] hold_q, hold_d;

	logic accept, cfg_we;
	logic [CNT_W-1:0] fc_dec, ic_dec, oc_dec, oc_dec2;

	// stores
	logic [SLOT_W-1:0] free_stack_q [MAX_SLOTS];
	logic [SLOT_W-1:0] in_stack_q [MAX_SLOTS];
	logic [SLOT_W-1:0] out_queue_q [MAX_SLOTS];

	logic [ADDR_W-1:0] free_raddr, in_raddr, out_raddr;
	logic [ADDR_W-1:0] free_waddr, in_waddr, out_waddr;
	logic [SLOT_W-1:0] free_wdata, in_wdata, out_wdata;
	logic free_we, in_we, out_we;
	logic [SLOT_W-1:0] free_rd_q, in_rd_q, out_rd_q, free_rdata;
	logic free_init_q;
	logic [ADDR_W-1:0] free_raddr_q;
	logic [CALC_W-1:0] free_init_val;

	logic push_en;
	logic [SLOT_W-1:0] push_val;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = !busy && !start;
	assign cfg_we = cfg_valid && cfg_ready;
	assign done = done_q;
	assign result = result_q;

	assign fc_dec = fc_q - CNT_W'(1);
	assign ic_dec = ic_q - CNT_W'(1);
	assign oc_dec = oc_q - CNT_W'(1);
	assign oc_dec2 = oc_q - CNT_W'(2);

	assign free_raddr = fc_dec[ADDR_W-1:0];
	assign in_raddr = ((state_q == S_IDLE && cmd.action == ACT_RELEASE) ||
		state_q == S_BULK_RD) ? ic_dec[ADDR_W-1:0] : '0;
	assign out_raddr = (state_q == S_IDLE) ?
		((oc_q > CNT_W'(1)) ? oc_dec2[ADDR_W-1:0] : '0) : oc_dec[ADDR_W-1:0];

	// free stack entries below the lowest written index still hold their refill value
	assign free_init_val = CALC_W'(eff_q) - CALC_W'(1) - CALC_W'(free_raddr_q);
	assign free_rdata = free_init_q ? free_init_val[SLOT_W-1:0] : free_rd_q;

	always_ff @(posedge clk) begin
		if (free_we) free_stack_q[free_waddr] <= free_wdata;
		free_rd_q <= free_stack_q[free_raddr];
		free_raddr_q <= free_raddr;
		free_init_q <= (CNT_W'(free_raddr) < low_q);
	end

	always_ff @(posedge clk) begin
		if (in_we) in_stack_q[in_waddr] <= in_wdata;
		in_rd_q <= in_stack_q[in_raddr];
	end

	always_ff @(posedge clk) begin
		if (out_we) out_queue_q[out_waddr] <= out_wdata;
		out_rd_q <= out_queue_q[out_raddr];
	end

	always_comb begin
		state_d = state_q;
		fc_d = fc_q;
		ic_d = ic_q;
		oc_d = oc_q;
		low_d = low_q;
		eff_d = eff_q;
		done_d = 1'b0;
		res_d.slot = '0;
		res_d.status = ST_OK;
		cmd_d = cmd_q;
		hold_d = hold_q;
		push_en = 1'b0;
		push_val = hold_q;
		free_we = 1'b0;
		free_waddr = fc_q[ADDR_W-1:0];
		free_wdata = push_val;
		in_we = 1'b0;
		in_waddr = ic_q[ADDR_W-1:0];
		in_wdata = free_rdata;
		out_we = 1'b0;
		out_waddr = oc_q[ADDR_W-1:0];
		out_wdata = free_rdata;

		case (state_q)
			S_IDLE: begin
				if (cfg_we) begin
					eff_d = eff_capacity(cfg_data);
					fc_d = eff_d;
					ic_d = '0;
					oc_d = '0;
					low_d = MAX_CNT;
				end else if (accept) begin
					cmd_d = cmd;
					state_d = S_USE;
					case (cmd.action)
						ACT_ALLOC: begin
							if (fc_q == '0) begin
								state_d = S_IDLE;
								done_d = 1'b1;
								res_d.status = ST_NO_FREE;
							end
						end
						ACT_RELEASE: begin
							if (ic_q == '0 && oc_q == '0) begin
								state_d = S_IDLE;
								done_d = 1'b1;
								res_d.status = ST_NOTHING;
							end
						end
						ACT_QUERY, ACT_BULK: begin
							if (ic_q == '0) begin
								state_d = S_IDLE;
								done_d = 1'b1;
								res_d.status = ST_NO_INPUT;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_USE: begin
				state_d = S_IDLE;
				case (cmd_q.action)
					ACT_ALLOC: begin
						fc_d = fc_dec;
						done_d = 1'b1;
						res_d.slot = free_rdata;
						if (cmd_q.is_store) begin
							if (oc_q < MAX_CNT) begin
								out_we = 1'b1;
								oc_d = oc_q + CNT_W'(1);
							end
						end else begin
							if (ic_q < MAX_CNT) begin
								in_we = 1'b1;
								ic_d = ic_q + CNT_W'(1);
							end
						end
					end
					ACT_RELEASE: begin
						if (ic_q != '0) begin
							ic_d = ic_dec;
							push_en = 1'b1;
							push_val = in_rd_q;
							done_d = 1'b1;
							res_d.slot = in_rd_q;
						end else if (oc_q > CNT_W'(1)) begin
							// second-newest output leaves, newest moves down into its place
							hold_d = out_rd_q;
							state_d = S_MOVE;
						end else begin
							oc_d = '0;
							push_en = 1'b1;
							push_val = out_rd_q;
							done_d = 1'b1;
							res_d.slot = out_rd_q;
						end
					end
					ACT_QUERY: begin
						done_d = 1'b1;
						res_d.slot = in_rd_q;
					end
					ACT_BULK: begin
						hold_d = in_rd_q;
						if (ic_q > CNT_W'(1)) begin
							state_d = S_BULK_RD;
						end else begin
							ic_d = '0;
							done_d = 1'b1;
							res_d.slot = in_rd_q;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MOVE: begin
				out_we = 1'b1;
				out_waddr = oc_dec2[ADDR_W-1:0];
				out_wdata = out_rd_q;
				oc_d = oc_dec;
				push_en = 1'b1;
				push_val = hold_q;
				done_d = 1'b1;
				res_d.slot = hold_q;
				state_d = S_IDLE;
			end
			S_BULK_RD: begin
				state_d = S_BULK_WR;
			end
			S_BULK_WR: begin
				// newest input goes back first, oldest one is kept
				push_en = 1'b1;
				push_val = in_rd_q;
				ic_d = ic_dec;
				if (ic_q > CNT_W'(2)) begin
					state_d = S_BULK_RD;
				end else begin
					ic_d = '0;
					done_d = 1'b1;
					res_d.slot = hold_q;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		if (push_en && fc_q < MAX_CNT) begin
			free_we = 1'b1;
			free_wdata = push_val;
			fc_d = fc_q + CNT_W'(1);
			if (fc_q < low_q) low_d = fc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eff_q <= eff_capacity(CAP_RESET);
			fc_q <= eff_capacity(CAP_RESET);
			ic_q <= '0;
			oc_q <= '0;
			low_q <= MAX_CNT;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			eff_q <= eff_d;
			fc_q <= fc_d;
			ic_q <= ic_d;
			oc_q <= oc_d;
			low_q <= low_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		cmd_q <= cmd_d;
		hold_q <= hold_d;
	end

endmodule

>>> hdl/rsa_checker.sv
// port-level checks for the register slot allocator, bound to the top level
module rsa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input rsa_pkg::result_t result,
	input logic             cfg_valid,
	input logic             cfg_ready
);
	import rsa_pkg::*;

	// the result strobe comes with the block free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted command either starts work or reports an error at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted command neither busy nor done");

	a_error_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.slot == '0)
		else $error("error result with nonzero slot");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a command transfer");

	// a capacity transfer produces no work and no result
	a_cfg_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !busy && !done)
		else $error("activity after capacity transfer");

endmodule

bind register_slot_allocator rsa_checker u_rsa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
